[rtl/core/delimiter_line_step_splitter_top_macros.svh]
// assertion macros for the delimiter line step splitter
// used by delimiter_line_step_splitter_top, no other dependencies
`ifndef DELIMITER_LINE_STEP_SPLITTER_TOP_MACROS_SVH
`define DELIMITER_LINE_STEP_SPLITTER_TOP_MACROS_SVH

// condition holds at every edge out of reset
`define DLSS_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define DLSS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define DLSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/dlss_pkg.sv]
// shared types and constants for the delimiter line step splitter
// no dependencies
`default_nettype none

package dlss_pkg;

   localparam int CHAR_FIELD_BITS = 16;
   localparam int STEP_BITS       = 32;
   localparam int COUNT_BITS      = 16;
   localparam int MATCH_BITS      = 4;

   localparam logic [COUNT_BITS-1:0] MAX_STEPS_RESET = 16'd32;

   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // marker matcher: leading whitespace, count of marker chars, full, fail
   localparam logic [MATCH_BITS-1:0] MATCH_LEAD = 4'd0;
   localparam logic [MATCH_BITS-1:0] MATCH_FULL = 4'd7;
   localparam logic [MATCH_BITS-1:0] MATCH_FAIL = 4'd8;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // one queued transaction: optional step result and optional closing result
   typedef struct packed {
      logic                  step_valid;
      logic [STEP_BITS-1:0]  step_start;
      logic [STEP_BITS-1:0]  step_length;
      logic [COUNT_BITS-1:0] step_number;
      logic                  close_valid;
      logic [COUNT_BITS-1:0] close_number;
      logic                  limit;
   } dlss_entry_type;

   // "%<step>"
   function automatic logic [7:0] marker_char(input logic [2:0] idx);
      logic [7:0] code;
      case (idx)
         3'd0: code = 8'h25;
         3'd1: code = 8'h3C;
         3'd2: code = 8'h73;
         3'd3: code = 8'h74;
         3'd4: code = 8'h65;
         3'd5: code = 8'h70;
         3'd6: code = 8'h3E;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

[rtl/core/dlss_req_if.sv]
// input channel of the splitter: one character per transaction
// depends on dlss_pkg
`default_nettype none

interface dlss_req_if;
   logic                                valid;
   logic                                ready;
   logic [dlss_pkg::CHAR_FIELD_BITS-1:0] char_code;
   logic                                last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

[rtl/core/dlss_rsp_if.sv]
// result channel of the splitter: step or closing result per transaction
// depends on dlss_pkg
`default_nettype none

interface dlss_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [dlss_pkg::STEP_BITS-1:0]  step_start;
   logic [dlss_pkg::STEP_BITS-1:0]  step_length;
   logic [dlss_pkg::COUNT_BITS-1:0] step_number;
   logic                            end_of_input;
   logic                            limit_hit;
   logic                            final_result;

   modport source (output valid, output step_start, output step_length, output step_number,
                   output end_of_input, output limit_hit, output final_result, input ready);
   modport sink (input valid, input step_start, input step_length, input step_number,
                 input end_of_input, input limit_hit, input final_result, output ready);
endinterface

`default_nettype wire

[rtl/core/delimiter_line_step_splitter_top.sv]
// a result is written into the result queue when its character is accepted
// throughput: one character per cycle; a step plus closing result is offered as two
//   output transactions, and the input stalls while both result queue entries wait
// reset: synchronous, active high; clears stream state and the queue,
//   max_steps returns to 32
// depends on dlss_pkg, dlss_req_if, dlss_rsp_if and the macros header
`default_nettype none
`include "delimiter_line_step_splitter_top_macros.svh"

module delimiter_line_step_splitter_top #(
   parameter int POS_BITS  = 32,
   parameter int CHAR_BITS = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   dlss_req_if.sink                             req_chan,
   dlss_rsp_if.source                           rsp_chan,
   input  wire logic                            csr_write_enable,
   input  wire logic [dlss_pkg::COUNT_BITS-1:0] csr_write_data
);
   import dlss_pkg::*;

   logic [POS_BITS-1:0]   char_position_ff, char_position_in;
   logic [POS_BITS-1:0]   step_begin_ff, step_begin_in;
   logic [POS_BITS-1:0]   line_begin_ff, line_begin_in;
   logic                  step_has_text_ff, step_has_text_in;
   logic                  line_has_text_ff, line_has_text_in;
   logic                  prev_line_crlf_ff, prev_line_crlf_in;
   logic                  cr_just_seen_ff, cr_just_seen_in;
   logic                  stopped_ff, stopped_in;
   logic [MATCH_BITS-1:0] match_ff, match_in;
   logic [COUNT_BITS-1:0] steps_ff, steps_in;
   logic [COUNT_BITS-1:0] max_steps_ff, max_steps_in;

   dlss_entry_type        queue_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_BITS-1:0] count_ff, count_in;
   logic                  phase_ff, phase_in;

   logic [CHAR_BITS-1:0]  ch;
   logic                  accept, last, is_lf, is_cr, is_ws, active;
   logic [MATCH_BITS-1:0] match_new, match_eff;
   logic                  line_text_eff, do_end, end_full;
   logic [POS_BITS-1:0]   next_pos, len_raw, len_dec, len_a, len_b;
   logic                  offer_a, emit_a, stop_a, offer_b, emit_b, stop_b;
   logic [POS_BITS-1:0]   step_begin_1;
   logic                  step_text_1, clear_step;
   logic [COUNT_BITS-1:0] steps_1, steps_final;
   logic                  stop_final;
   dlss_entry_type        entry, head;
   logic                  push, show_step, pop_sub, pop_item;

   // character decode
   assign accept = req_chan.valid && req_chan.ready;
   assign last   = req_chan.last_char;
   assign ch     = CHAR_BITS'(req_chan.char_code);
   assign is_lf  = (ch == CHAR_BITS'(CHAR_LF));
   assign is_cr  = (ch == CHAR_BITS'(CHAR_CR));
   assign is_ws  = (ch >= CHAR_BITS'(CHAR_TAB) && ch <= CHAR_BITS'(CHAR_CR))
                   || ch == CHAR_BITS'(CHAR_SPACE);
   assign active = !stopped_ff;

   // delimiter matcher
   always_comb begin
      if (match_ff == MATCH_LEAD) begin
         if (is_ws) match_new = MATCH_LEAD;
         else if (ch == CHAR_BITS'(marker_char(3'd0))) match_new = MATCH_LEAD + 4'd1;
         else match_new = MATCH_FAIL;
      end else if (match_ff < MATCH_FULL) begin
         match_new = (ch == CHAR_BITS'(marker_char(match_ff[2:0]))) ? match_ff + 4'd1
                                                                     : MATCH_FAIL;
      end else if (match_ff == MATCH_FULL) begin
         match_new = is_ws ? MATCH_FULL : MATCH_FAIL;
      end else begin
         match_new = MATCH_FAIL;
      end
   end

   // line end handling, at LF or at the last character
   assign next_pos      = char_position_ff + POS_BITS'(1);
   assign do_end        = is_lf || last;
   assign match_eff     = is_lf ? match_ff : match_new;
   assign line_text_eff = is_lf ? line_has_text_ff : (line_has_text_ff || !is_ws);
   assign end_full      = do_end && (match_eff == MATCH_FULL);

   // drop the LF or CRLF ahead of the delimiter line
   assign len_raw = line_begin_ff - step_begin_ff;
   assign len_dec = len_raw - POS_BITS'(1);
   always_comb begin
      if (len_raw == '0) len_a = len_raw;
      else if (len_dec != '0 && prev_line_crlf_ff) len_a = len_dec - POS_BITS'(1);
      else len_a = len_dec;
   end

   assign offer_a = end_full && step_has_text_ff;
   assign emit_a  = offer_a && (steps_ff < max_steps_ff);
   assign stop_a  = offer_a && (steps_ff >= max_steps_ff);

   assign clear_step   = end_full && !stop_a;
   assign step_begin_1 = clear_step ? next_pos : step_begin_ff;
   always_comb begin
      if (clear_step) step_text_1 = 1'b0;
      else if (do_end && !end_full && line_text_eff) step_text_1 = 1'b1;
      else step_text_1 = step_has_text_ff;
   end
   assign steps_1 = steps_ff + COUNT_BITS'(emit_a);

   // closing step at the last character
   assign offer_b = last && !stop_a && step_text_1;
   assign emit_b  = offer_b && (steps_1 < max_steps_ff);
   assign stop_b  = offer_b && (steps_1 >= max_steps_ff);
   assign len_b   = next_pos - step_begin_1;

   assign stop_final  = stopped_ff || (stop_a || stop_b);
   assign steps_final = active ? steps_1 + COUNT_BITS'(emit_b) : steps_ff;

   always_comb begin
      entry = '0;
      entry.step_valid   = active && (emit_a || emit_b);
      entry.step_start   = emit_a ? STEP_BITS'(step_begin_ff) : STEP_BITS'(step_begin_1);
      entry.step_length  = emit_a ? STEP_BITS'(len_a) : STEP_BITS'(len_b);
      entry.step_number  = emit_a ? steps_ff : steps_1;
      entry.close_valid  = last;
      entry.close_number = steps_final;
      entry.limit        = stop_final;
   end
   assign push = accept && (entry.step_valid || entry.close_valid);

   // stream state update
   always_comb begin
      char_position_in  = char_position_ff;
      step_begin_in     = step_begin_ff;
      line_begin_in     = line_begin_ff;
      step_has_text_in  = step_has_text_ff;
      line_has_text_in  = line_has_text_ff;
      prev_line_crlf_in = prev_line_crlf_ff;
      cr_just_seen_in   = cr_just_seen_ff;
      stopped_in        = stopped_ff;
      match_in          = match_ff;
      steps_in          = steps_ff;
      if (accept) begin
         if (last) begin
            char_position_in  = '0;
            step_begin_in     = '0;
            line_begin_in     = '0;
            step_has_text_in  = 1'b0;
            line_has_text_in  = 1'b0;
            prev_line_crlf_in = 1'b0;
            cr_just_seen_in   = 1'b0;
            stopped_in        = 1'b0;
            match_in          = MATCH_LEAD;
            steps_in          = '0;
         end else if (active) begin
            char_position_in  = next_pos;
            step_begin_in     = step_begin_1;
            step_has_text_in  = step_text_1;
            line_begin_in     = is_lf ? next_pos : line_begin_ff;
            line_has_text_in  = is_lf ? 1'b0 : line_text_eff;
            prev_line_crlf_in = is_lf ? cr_just_seen_ff : prev_line_crlf_ff;
            match_in          = is_lf ? MATCH_LEAD : match_new;
            cr_just_seen_in   = is_cr;
            stopped_in        = stop_a;
            steps_in          = steps_1;
         end
      end
   end

   assign max_steps_in = csr_write_enable ? csr_write_data : max_steps_ff;

   // result queue, one entry per transaction that yields results
   assign head      = queue_ff[rd_ptr_ff];
   assign show_step = head.step_valid && !phase_ff;
   assign pop_sub   = rsp_chan.valid && rsp_chan.ready;
   assign pop_item  = pop_sub && (!show_step || !head.close_valid);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop_item ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + QCOUNT_BITS'(push) - QCOUNT_BITS'(pop_item);
      if (pop_sub && show_step && head.close_valid) phase_in = 1'b1;
      else if (pop_item) phase_in = 1'b0;
      else phase_in = phase_ff;
   end

   assign req_chan.ready = (count_ff != QCOUNT_BITS'(QUEUE_DEPTH));

   assign rsp_chan.valid        = (count_ff != '0);
   assign rsp_chan.step_start   = show_step ? head.step_start : '0;
   assign rsp_chan.step_length  = show_step ? head.step_length : '0;
   assign rsp_chan.step_number  = show_step ? head.step_number : head.close_number;
   assign rsp_chan.end_of_input = !show_step;
   assign rsp_chan.limit_hit    = show_step ? 1'b0 : head.limit;
   assign rsp_chan.final_result = show_step ? !head.close_valid : 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         char_position_ff  <= '0;
         step_begin_ff     <= '0;
         line_begin_ff     <= '0;
         step_has_text_ff  <= 1'b0;
         line_has_text_ff  <= 1'b0;
         prev_line_crlf_ff <= 1'b0;
         cr_just_seen_ff   <= 1'b0;
         stopped_ff        <= 1'b0;
         match_ff          <= MATCH_LEAD;
         steps_ff          <= '0;
         max_steps_ff      <= MAX_STEPS_RESET;
         wr_ptr_ff         <= '0;
         rd_ptr_ff         <= '0;
         count_ff          <= '0;
         phase_ff          <= 1'b0;
      end else begin
         char_position_ff  <= char_position_in;
         step_begin_ff     <= step_begin_in;
         line_begin_ff     <= line_begin_in;
         step_has_text_ff  <= step_has_text_in;
         line_has_text_ff  <= line_has_text_in;
         prev_line_crlf_ff <= prev_line_crlf_in;
         cr_just_seen_ff   <= cr_just_seen_in;
         stopped_ff        <= stopped_in;
         match_ff          <= match_in;
         steps_ff          <= steps_in;
         max_steps_ff      <= max_steps_in;
         wr_ptr_ff         <= wr_ptr_in;
         rd_ptr_ff         <= rd_ptr_in;
         count_ff          <= count_in;
         phase_ff          <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

   `DLSS_ASSERT_ALWAYS(a_queue_bound, clock, reset,
      count_ff <= QCOUNT_BITS'(QUEUE_DEPTH), "result queue overflow")
   `DLSS_ASSERT_NEXT(a_stream_cleared, clock, reset, accept && last,
      char_position_ff == '0 && steps_ff == '0 && !stopped_ff, "stream not cleared")
   `DLSS_ASSERT_SAME(a_no_step_when_stopped, clock, reset, stopped_ff,
      !(push && entry.step_valid), "step result after limit")
   `DLSS_ASSERT_SAME(a_phase_has_pair, clock, reset, phase_ff,
      count_ff != '0 && head.step_valid && head.close_valid, "closing phase without pair")

endmodule

`default_nettype wire
